// ===== src/pp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pad pedestal accumulator.
// Depends on nothing; used by every module of the block.
package pp_pkg;

  // command codes
  localparam logic [1:0] CMD_HIT  = 2'd0;
  localparam logic [1:0] CMD_EOE  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_NO_EVENTS = 3'd2;
  localparam logic [2:0] ST_NEG_VAR   = 3'd3;
  localparam logic [2:0] ST_SECTOR    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_SECTOR_ENABLE = 2'd0;
  localparam logic [1:0] REG_ROW_LIMIT     = 2'd1;
  localparam logic [1:0] REG_COL_LIMIT     = 2'd2;

  // reset values of the configuration registers
  localparam logic [5:0] SECTOR_ENABLE_RST = 6'd63;
  localparam logic [6:0] ROW_LIMIT_RST     = 7'd90;
  localparam logic [6:0] COL_LIMIT_RST     = 7'd92;

  // sectors six and seven never count as enabled
  localparam logic [3:0] SECTOR_CAP = 4'd6;

  // field widths
  localparam int SUM_W  = 34;
  localparam int SQ_W   = 44;
  localparam int CNT_W  = 24;
  localparam int DIV_W  = 56;  // widest dividend: square sum shifted by 12
  localparam int DSR_W  = 24;  // divisor: event count
  localparam int ROOT_W = 28;  // root of a 56 bit radicand
  localparam int MEAN_W = 16;

  // one pad entry of the accumulator memory
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] hits;
  } entry_t;

endpackage

// ===== src/pad_pedestal_accumulator_top.sv =====
`timescale 1ns / 1ps
// Top level of the pad pedestal accumulator: control, pad memory, config.
// Depends on pp_pkg, pp_div and pp_isqrt.
//
//  channel | ports                               | direction
//  in      | in_valid/in_ready, command..charge  | word in
//  out     | out_valid/out_ready, status..counts | word out
//  cfg     | cfg_valid/cfg_ready, index, data    | register write
//
// One word at a time. A hit passes through accept, memory read,
// read-modify-write and output. A full read runs two 56-step serial
// divisions, a 28-step serial square root and the control states between.
// Reset: a clearing pass writes all SECTORS*MAX_COLS*MAX_ROWS pad entries
// (55296 by default), one per cycle, with in_ready low; config writes are
// taken throughout.
// Stalls: a result waits in the output register; a new word is taken once
// the previous result has been moved there.
module pad_pedestal_accumulator_top #(
  parameter int SECTORS  = 6,
  parameter int MAX_ROWS = 96,
  parameter int MAX_COLS = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_sector,
  input  logic [6:0]  in_pad_col,
  input  logic [6:0]  in_pad_row,
  input  logic [9:0]  in_charge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_mean,
  output logic [15:0] out_sigma,
  output logic [23:0] out_hit_count,
  output logic [23:0] out_event_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int PADS   = SECTORS * MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(PADS);
  localparam logic [ADDR_W-1:0] LAST_PAD = ADDR_W'(PADS - 1);
  localparam int SUM_W = pp_pkg::SUM_W;
  localparam int SQ_W  = pp_pkg::SQ_W;
  localparam int CNT_W = pp_pkg::CNT_W;
  localparam int DIV_W = pp_pkg::DIV_W;
  localparam int RT_W  = pp_pkg::ROOT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_MOD, S_DIVM, S_DIVQ, S_MUL, S_CMP, S_SQRT, S_RESP
  } state_t;

  state_t                state_r;
  logic [ADDR_W-1:0]     clr_r;
  logic [1:0]            cmd_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [2:0]            stat_r;
  logic [CNT_W-1:0]      hits_r;
  logic [15:0]           mean_r;
  logic [15:0]           sigma_r;
  logic [9:0]            q_r;
  logic [RT_W-1:0]       m_r;
  logic                  m_big_r;
  logic [DIV_W-1:0]      q2_r;
  logic [DIV_W-1:0]      mm_r;
  logic [CNT_W-1:0]      events_r;
  logic                  had_hit_r;
  logic [5:0]            sect_en_r;
  logic [6:0]            row_lim_r;
  logic [6:0]            col_lim_r;
  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic [15:0]           out_mean_r;
  logic [15:0]           out_sigma_r;
  logic [CNT_W-1:0]      out_hits_r;
  logic [CNT_W-1:0]      out_events_r;

  pp_pkg::entry_t        mem_r [PADS];
  pp_pkg::entry_t        rd_q;
  pp_pkg::entry_t        upd;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  pp_pkg::entry_t        wr_data;

  logic                  accept;
  logic                  slot_free;
  logic                  sec_ok;
  logic                  pad_ok;
  logic [2:0]            loc_stat;
  logic [ADDR_W-1:0]     loc_addr;
  logic [SUM_W:0]        sum_add;
  logic [SQ_W:0]         sq_add;
  logic [19:0]           q_sq;
  logic [DIV_W-1:0]      m_sq;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;
  logic                  sq_start;
  logic                  sq_done;
  logic [RT_W-1:0]       sq_root;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;

  // locate the pad: sector check first, then the row and column limits
  assign sec_ok = ({1'b0, in_sector} < 4'(SECTORS))
                  && ({1'b0, in_sector} < pp_pkg::SECTOR_CAP)
                  && sect_en_r[in_sector];
  assign pad_ok = (in_pad_row < row_lim_r) && ({1'b0, in_pad_row} < 8'(MAX_ROWS))
                  && (in_pad_col < col_lim_r) && ({1'b0, in_pad_col} < 8'(MAX_COLS));
  assign loc_stat = !sec_ok ? pp_pkg::ST_SECTOR
                            : (!pad_ok ? pp_pkg::ST_RANGE : pp_pkg::ST_OK);
  assign loc_addr = (ADDR_W'(in_sector) * ADDR_W'(MAX_COLS) + ADDR_W'(in_pad_col))
                    * ADDR_W'(MAX_ROWS) + ADDR_W'(in_pad_row);

  // saturating update of one pad entry
  assign q_sq    = q_r * q_r;
  assign sum_add = {1'b0, rd_q.sum} + (SUM_W+1)'(q_r);
  assign sq_add  = {1'b0, rd_q.sq} + (SQ_W+1)'(q_sq);
  always_comb begin
    upd.sum  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    upd.sq   = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
    upd.hits = (&rd_q.hits) ? rd_q.hits : rd_q.hits + 1'b1;
  end

  // square of the mean, full width
  assign m_sq = DIV_W'(m_r) * DIV_W'(m_r);

  // memory write port: clearing pass, else the hit write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = upd;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (state_r == S_MOD && cmd_r == pp_pkg::CMD_HIT) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q <= mem_r[addr_r];
  end

  // shared divider: mean first, then the mean square
  assign div_start    = (state_r == S_MOD && cmd_r == pp_pkg::CMD_READ && events_r != '0)
                        || (state_r == S_DIVM && div_done);
  assign div_dividend = (state_r == S_DIVM) ? {rd_q.sq, 12'b0}
                                            : DIV_W'({rd_q.sum, 6'b0});
  assign sq_start     = (state_r == S_CMP) && !m_big_r && !(q2_r < mm_r);

  pp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (events_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  pp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (q2_r - mm_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sect_en_r <= pp_pkg::SECTOR_ENABLE_RST;
      row_lim_r <= pp_pkg::ROW_LIMIT_RST;
      col_lim_r <= pp_pkg::COL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pp_pkg::REG_SECTOR_ENABLE: sect_en_r <= cfg_data[5:0];
        pp_pkg::REG_ROW_LIMIT:     row_lim_r <= cfg_data;
        pp_pkg::REG_COL_LIMIT:     col_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      events_r    <= '0;
      had_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_PAD) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= in_command;
            addr_r  <= loc_addr;
            q_r     <= in_charge;
            stat_r  <= pp_pkg::ST_OK;
            hits_r  <= '0;
            mean_r  <= '0;
            sigma_r <= '0;
            state_r <= S_RESP;
            unique case (in_command)
              pp_pkg::CMD_HIT: begin
                had_hit_r <= 1'b1;
                stat_r    <= loc_stat;
                if (loc_stat == pp_pkg::ST_OK) begin
                  state_r <= S_RD;
                end
              end
              pp_pkg::CMD_EOE: begin
                if (had_hit_r && !(&events_r)) begin
                  events_r <= events_r + 1'b1;
                end
                had_hit_r <= 1'b0;
              end
              pp_pkg::CMD_READ: begin
                stat_r <= loc_stat;
                if (loc_stat == pp_pkg::ST_OK) begin
                  state_r <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (cmd_r == pp_pkg::CMD_HIT) begin
            hits_r  <= upd.hits;
            state_r <= S_RESP;
          end else begin
            hits_r <= rd_q.hits;
            if (events_r == '0) begin
              stat_r  <= pp_pkg::ST_NO_EVENTS;
              state_r <= S_RESP;
            end else begin
              state_r <= S_DIVM;
            end
          end
        end
        S_DIVM: begin
          if (div_done) begin
            m_r     <= div_quot[RT_W-1:0];
            m_big_r <= |div_quot[DIV_W-1:RT_W];
            state_r <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            q2_r    <= div_quot;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          mm_r    <= m_sq;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (m_big_r || q2_r < mm_r) begin
            stat_r  <= pp_pkg::ST_NEG_VAR;
            state_r <= S_RESP;
          end else begin
            mean_r  <= (|m_r[RT_W-1:16]) ? 16'hFFFF : m_r[15:0];
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            sigma_r <= (|sq_root[RT_W-1:16]) ? 16'hFFFF : sq_root[15:0];
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= stat_r;
            out_mean_r   <= mean_r;
            out_sigma_r  <= sigma_r;
            out_hits_r   <= hits_r;
            out_events_r <= events_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_mean        = out_mean_r;
  assign out_sigma       = out_sigma_r;
  assign out_hit_count   = out_hits_r;
  assign out_event_count = out_events_r;

  // a hit on a good pad goes to the memory read
  a_hit_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == pp_pkg::CMD_HIT && loc_stat == pp_pkg::ST_OK |=> state_r == S_RD)
    else $error("accepted hit did not start a memory read");

  // the pad memory is written only by clearing or by a hit write-back
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CLEAR) || (state_r == S_MOD && cmd_r == pp_pkg::CMD_HIT))
    else $error("unexpected pad memory write");

  // a failed read carries no mean or sigma
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != pp_pkg::ST_OK |-> out_mean_r == '0 && out_sigma_r == '0)
    else $error("mean or sigma set on a failed word");

  // no word is taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("input ready while clearing");

endmodule

// ===== src/pp_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on pp_pkg for the operand widths.
module pp_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [pp_pkg::DIV_W-1:0] dividend,
  input  logic [pp_pkg::DSR_W-1:0] divisor,
  output logic                     done,
  output logic [pp_pkg::DIV_W-1:0] quotient
);

  localparam int CW = $clog2(pp_pkg::DIV_W);
  localparam logic [CW-1:0] LAST = CW'(pp_pkg::DIV_W - 1);

  logic                     busy_r;
  logic                     done_r;
  logic [CW-1:0]            cnt_r;
  logic [pp_pkg::DSR_W-1:0] rem_r;
  logic [pp_pkg::DSR_W-1:0] dsr_r;
  logic [pp_pkg::DIV_W-1:0] quo_r;
  logic [pp_pkg::DSR_W:0]   trial;
  logic                     ge;

  // shift the next dividend bit into the remainder and compare
  assign trial = {rem_r, quo_r[pp_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= ge ? pp_pkg::DSR_W'(trial - {1'b0, dsr_r}) : trial[pp_pkg::DSR_W-1:0];
        quo_r <= {quo_r[pp_pkg::DIV_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/pp_isqrt.sv =====
`timescale 1ns / 1ps
// Integer square root, one root bit per cycle (digit by digit).
// Depends on pp_pkg for the radicand and root widths.
module pp_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pp_pkg::DIV_W-1:0]  radicand,
  output logic                      done,
  output logic [pp_pkg::ROOT_W-1:0] root
);

  localparam int RW = pp_pkg::ROOT_W + 2;
  localparam int CW = $clog2(pp_pkg::ROOT_W);
  localparam logic [CW-1:0] LAST = CW'(pp_pkg::ROOT_W - 1);

  logic                      busy_r;
  logic                      done_r;
  logic [CW-1:0]             cnt_r;
  logic [pp_pkg::DIV_W-1:0]  val_r;
  logic [RW-1:0]             rem_r;
  logic [pp_pkg::ROOT_W-1:0] root_r;
  logic [RW+1:0]             t;
  logic [RW+1:0]             trial;
  logic                      ge;

  // bring down two radicand bits and try root*4+1
  assign t     = {rem_r, val_r[pp_pkg::DIV_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        val_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? RW'(t - trial) : t[RW-1:0];
        root_r <= {root_r[pp_pkg::ROOT_W-2:0], ge};
        val_r  <= {val_r[pp_pkg::DIV_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pad_pedestal_accumulator_top: directed table, then random phases.
// Depends on pp_pkg and the accumulator RTL; results are checked against an in-bench predictor.
module tb;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int N_SECT = 6;
  localparam int N_ROWS = 96;
  localparam int N_COLS = 96;
  localparam int WATCHDOG_LIMIT = 250000;  // covers the clearing pass after reset
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 235;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] sector;
    logic [6:0] col;
    logic [6:0] row;
    logic [9:0] charge;
  } pad_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] mean;
    logic [15:0] sigma;
    logic [23:0] hits;
    logic [23:0] events;
  } pad_result_t;

  typedef struct packed {
    pad_word_t   word;
    logic        typed;
    pad_result_t res;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [2:0]  in_sector;
  logic [6:0]  in_pad_col;
  logic [6:0]  in_pad_row;
  logic [9:0]  in_charge;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_mean;
  logic [15:0] out_sigma;
  logic [23:0] out_hit_count;
  logic [23:0] out_event_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  pad_pedestal_accumulator_top u_dut (.*);

  // predictor state
  longint unsigned pad_sum[int];
  longint unsigned pad_square_sum[int];
  int unsigned     pad_hit_count[int];
  int unsigned     events_seen;
  bit              event_open;
  logic [5:0]      sector_mask;
  logic [6:0]      row_cap;
  logic [6:0]      col_cap;

  pad_result_t expected_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // map a pad address to a store index, or give the reject status
  function automatic logic [2:0] pad_lookup(pad_word_t w, output int idx);
    idx = 0;
    if (w.sector >= N_SECT || !sector_mask[w.sector]) return pp_pkg::ST_SECTOR;
    if (w.row >= row_cap || w.row >= N_ROWS || w.col >= col_cap || w.col >= N_COLS)
      return pp_pkg::ST_RANGE;
    idx = (int'(w.sector) * N_COLS + int'(w.col)) * N_ROWS + int'(w.row);
    return pp_pkg::ST_OK;
  endfunction

  // advance the pedestal state by one word and give its result
  function automatic pad_result_t pedestal_predict(pad_word_t w);
    pad_result_t     r;
    int              idx;
    longint unsigned s, s2, m, q2, sd;
    r = '0;
    case (w.cmd)
      pp_pkg::CMD_HIT: begin
        event_open = 1'b1;
        r.status = pad_lookup(w, idx);
        if (r.status == pp_pkg::ST_OK) begin
          if (!pad_sum.exists(idx)) begin
            pad_sum[idx] = 0;
            pad_square_sum[idx] = 0;
            pad_hit_count[idx] = 0;
          end
          s  = pad_sum[idx] + w.charge;
          s2 = pad_square_sum[idx] + longint'(w.charge) * w.charge;
          pad_sum[idx]        = s > (64'd1 << 34) - 1 ? (64'd1 << 34) - 1 : s;
          pad_square_sum[idx] = s2 > (64'd1 << 44) - 1 ? (64'd1 << 44) - 1 : s2;
          if (pad_hit_count[idx] < 24'hFFFFFF) pad_hit_count[idx]++;
          r.hits = 24'(pad_hit_count[idx]);
        end
      end
      pp_pkg::CMD_EOE: begin
        if (event_open && events_seen < 24'hFFFFFF) events_seen++;
        event_open = 1'b0;
      end
      pp_pkg::CMD_READ: begin
        r.status = pad_lookup(w, idx);
        if (r.status == pp_pkg::ST_OK) begin
          s  = pad_sum.exists(idx) ? pad_sum[idx] : 0;
          s2 = pad_sum.exists(idx) ? pad_square_sum[idx] : 0;
          r.hits = pad_sum.exists(idx) ? 24'(pad_hit_count[idx]) : 24'd0;
          if (events_seen == 0) begin
            r.status = pp_pkg::ST_NO_EVENTS;
          end else begin
            m  = (s << 6) / events_seen;
            q2 = (s2 << 12) / events_seen;
            if (m >= (64'd1 << 28) || q2 < m * m) begin
              r.status = pp_pkg::ST_NEG_VAR;
            end else begin
              sd = int_sqrt(q2 - m * m);
              r.mean  = m > 16'hFFFF ? 16'hFFFF : m[15:0];
              r.sigma = sd > 16'hFFFF ? 16'hFFFF : sd[15:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.events = 24'(events_seen);
    return r;
  endfunction

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pad_word_t random_word();
    pad_word_t w;
    int p;
    p = $urandom_range(0, 99);
    w.cmd = p < 68 ? pp_pkg::CMD_HIT : p < 82 ? pp_pkg::CMD_EOE :
            p < 97 ? pp_pkg::CMD_READ : CMD_UNKNOWN;
    w.sector = $urandom_range(0, 99) < 88 ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
    if ($urandom_range(0, 99) < 80) begin
      w.col = 7'($urandom_range(0, 3));
      w.row = 7'($urandom_range(0, 3));
    end else begin
      w.col = 7'($urandom);
      w.row = 7'($urandom);
    end
    p = $urandom_range(0, 19);
    w.charge = p == 0 ? 10'd0 : p == 1 ? 10'd1023 : 10'($urandom);
    return w;
  endfunction

  // present one word and hold it until taken
  task automatic send_word(pad_word_t w, bit typed, pad_result_t typed_res);
    pad_result_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= w.cmd;
    in_sector  <= w.sector;
    in_pad_col <= w.col;
    in_pad_row <= w.row;
    in_charge  <= w.charge;
    do @(posedge clk); while (!in_ready);
    r = pedestal_predict(w);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  // write one register, then drop valid for a cycle
  task automatic write_reg(logic [1:0] index, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      pp_pkg::REG_SECTOR_ENABLE: sector_mask = data[5:0];
      pp_pkg::REG_ROW_LIMIT:     row_cap = data;
      pp_pkg::REG_COL_LIMIT:     col_cap = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    pad_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, status %0d", out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status || out_mean !== e.mean || out_sigma !== e.sigma ||
            out_hit_count !== e.hits || out_event_count !== e.events) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d mean %0d sig %0d hits %0d ev %0d, ",
                      "got %0d %0d %0d %0d %0d"},
                     e.status, e.mean, e.sigma, e.hits, e.events, out_status, out_mean,
                     out_sigma, out_hit_count, out_event_count);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int p;
    p = $urandom_range(0, 99);
    if (calm) out_ready <= 1'b1;
    else if (p < 70) out_ready <= 1'b1;
    else if (p < 97) out_ready <= 1'b0;
    else out_ready <= ~out_ready;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    table_row_t  dir[$];
    pad_result_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_command = '0; in_sector = '0;
    in_pad_col = '0; in_pad_row = '0; in_charge = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    calm = 1'b0;
    events_seen = 0; event_open = 1'b0;
    sector_mask = pp_pkg::SECTOR_ENABLE_RST;
    row_cap = pp_pkg::ROW_LIMIT_RST;
    col_cap = pp_pkg::COL_LIMIT_RST;

    // directed words: typed results where obvious, predictor otherwise
    dir = '{
      '{'{pp_pkg::CMD_READ, 3'd0, 7'd0, 7'd0, 10'd0}, 1'b1,
        '{pp_pkg::ST_NO_EVENTS, 16'd0, 16'd0, 24'd0, 24'd0}},
      '{'{pp_pkg::CMD_HIT, 3'd6, 7'd0, 7'd0, 10'd5}, 1'b1,
        '{pp_pkg::ST_SECTOR, 16'd0, 16'd0, 24'd0, 24'd0}},
      '{'{pp_pkg::CMD_EOE, 3'd0, 7'd0, 7'd0, 10'd0}, 1'b1,
        '{pp_pkg::ST_OK, 16'd0, 16'd0, 24'd0, 24'd1}},
      '{'{pp_pkg::CMD_HIT, 3'd0, 7'd0, 7'd0, 10'd1023}, 1'b1,
        '{pp_pkg::ST_OK, 16'd0, 16'd0, 24'd1, 24'd1}},
      '{'{pp_pkg::CMD_EOE, 3'd7, 7'd127, 7'd127, 10'd1023}, 1'b1,
        '{pp_pkg::ST_OK, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_READ, 3'd0, 7'd0, 7'd0, 10'd0}, 1'b1,
        '{pp_pkg::ST_OK, 16'd32736, 16'd32736, 24'd1, 24'd2}},
      '{'{pp_pkg::CMD_EOE, 3'd0, 7'd0, 7'd0, 10'd0}, 1'b1,
        '{pp_pkg::ST_OK, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_HIT, 3'd7, 7'd1, 7'd1, 10'd1}, 1'b1,
        '{pp_pkg::ST_SECTOR, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_HIT, 3'd1, 7'd0, 7'd127, 10'd1}, 1'b1,
        '{pp_pkg::ST_RANGE, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_HIT, 3'd1, 7'd127, 7'd0, 10'd1}, 1'b1,
        '{pp_pkg::ST_RANGE, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_HIT, 3'd1, 7'd92, 7'd0, 10'd1}, 1'b1,
        '{pp_pkg::ST_RANGE, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_HIT, 3'd1, 7'd0, 7'd90, 10'd1}, 1'b1,
        '{pp_pkg::ST_RANGE, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_HIT, 3'd5, 7'd91, 7'd89, 10'd0}, 1'b1,
        '{pp_pkg::ST_OK, 16'd0, 16'd0, 24'd1, 24'd2}},
      '{'{CMD_UNKNOWN, 3'd5, 7'd91, 7'd89, 10'd1023}, 1'b1,
        '{pp_pkg::ST_OK, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_READ, 3'd6, 7'd0, 7'd0, 10'd0}, 1'b1,
        '{pp_pkg::ST_SECTOR, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_READ, 3'd2, 7'd100, 7'd0, 10'd0}, 1'b1,
        '{pp_pkg::ST_RANGE, 16'd0, 16'd0, 24'd0, 24'd2}},
      '{'{pp_pkg::CMD_HIT, 3'd0, 7'd1, 7'd1, 10'd1000}, 1'b0, none},
      '{'{pp_pkg::CMD_HIT, 3'd0, 7'd1, 7'd1, 10'd1000}, 1'b0, none},
      '{'{pp_pkg::CMD_EOE, 3'd0, 7'd0, 7'd0, 10'd0}, 1'b0, none},
      '{'{pp_pkg::CMD_READ, 3'd0, 7'd1, 7'd1, 10'd0}, 1'b0, none},
      '{'{pp_pkg::CMD_READ, 3'd5, 7'd91, 7'd89, 10'd0}, 1'b0, none},
      '{'{pp_pkg::CMD_READ, 3'd3, 7'd50, 7'd60, 10'd0}, 1'b0, none}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir[i]) send_word(dir[i].word, dir[i].typed, dir[i].res);

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: ;  // reset setting
        1: begin
          write_reg(pp_pkg::REG_SECTOR_ENABLE, 7'd63);
          write_reg(pp_pkg::REG_ROW_LIMIT, 7'd96);
          write_reg(pp_pkg::REG_COL_LIMIT, 7'd96);
        end
        2: write_reg(pp_pkg::REG_SECTOR_ENABLE, 7'd0);
        3: begin
          write_reg(pp_pkg::REG_SECTOR_ENABLE, 7'($urandom_range(1, 63)));
          write_reg(pp_pkg::REG_ROW_LIMIT, 7'd1);
          write_reg(pp_pkg::REG_COL_LIMIT, 7'd1);
        end
        default: begin
          write_reg(pp_pkg::REG_SECTOR_ENABLE, 7'($urandom_range(0, 63)));
          write_reg(pp_pkg::REG_ROW_LIMIT, 7'($urandom_range(1, 96)));
          write_reg(pp_pkg::REG_COL_LIMIT, 7'($urandom_range(1, 96)));
        end
      endcase
      calm = (ph == 4);
      for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(random_word(), 1'b0, none);
    end

    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
